/* rtl/tbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket shaper package
// Sizes, codes and word layouts shared by the shaper modules.
// ----------------------------------------------------------------------------
package tbs_pkg;

	// Queue sizing.
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

	// Field widths.
	localparam int TOK_W    = 16;
	localparam int NUM_W    = 16;
	localparam int CNT_W    = 16;
	localparam int STATUS_W = 3;
	localparam int QCNT_W   = 5;

	// Stream word widths.
	localparam int IN_TDATA_W   = 16;
	localparam int OUT_FIELDS_W = NUM_W + 1 + NUM_W + TOK_W + TOK_W + QCNT_W + CNT_W + CNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Register port.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_BUCKET_DEPTH = 1'b0;
	localparam logic [TOK_W-1:0] DEPTH_RESET = 16'd10;

	// Event kind carried on the input tuser.
	typedef enum logic {
		FUNC_PACKET = 1'b0,
		FUNC_TICK   = 1'b1
	} func_t;

	// Status of one event.
	typedef enum logic [STATUS_W-1:0] {
		ST_QUEUED   = 3'd0,
		ST_TOO_BIG  = 3'd1,
		ST_Q_FULL   = 3'd2,
		ST_TOK_ADD  = 3'd3,
		ST_TOK_DROP = 3'd4
	} status_t;

	// One waiting packet.
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [TOK_W-1:0] need;
	} entry_t;

	// Queue commands from the core.
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t wr_entry;
	} q_ctrl_t;

	// Queue status to the core.
	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              full;
		entry_t            head;
	} q_stat_t;

	// One result word.
	typedef struct packed {
		status_t           status;
		logic [NUM_W-1:0]  pnum;
		logic              released;
		logic [NUM_W-1:0]  rel_num;
		logic [TOK_W-1:0]  rel_tokens;
		logic [TOK_W-1:0]  level;
		logic [QCNT_W-1:0] qcount;
		logic [CNT_W-1:0]  pkt_drop;
		logic [CNT_W-1:0]  tok_drop;
	} result_t;

endpackage
`default_nettype wire

/* rtl/tbs_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket shaper wait queue
// Circular buffer of waiting packets with a head pointer and fill count.
// ----------------------------------------------------------------------------
module tbs_queue
	import tbs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_ctrl_t ctrl,
	output q_stat_t      stat
);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  head_q;
	logic [FILL_W-1:0] fill_q;
	logic [PTR_W:0]    tail_sum;
	logic [PTR_W:0]    head_sum;
	logic [PTR_W-1:0]  tail_idx;
	logic [PTR_W-1:0]  head_nxt;

	// Tail slot and next head, both wrapped at the queue depth.
	always_comb begin
		tail_sum = {1'b0, head_q} + {1'b0, fill_q[PTR_W-1:0]};
		head_sum = {1'b0, head_q} + (PTR_W+1)'(1);
		if (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
			tail_idx = PTR_W'(tail_sum - (PTR_W+1)'(QUEUE_DEPTH));
		end else begin
			tail_idx = tail_sum[PTR_W-1:0];
		end
		if (head_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
			head_nxt = PTR_W'(head_sum - (PTR_W+1)'(QUEUE_DEPTH));
		end else begin
			head_nxt = head_sum[PTR_W-1:0];
		end
	end

	// Entry storage; only occupied entries are ever read.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[tail_idx] <= ctrl.wr_entry;
		end
	end

	// Head pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctrl.pop) begin
				head_q <= head_nxt;
			end
			case ({ctrl.push, ctrl.pop})
				2'b10:   fill_q <= fill_q + FILL_W'(1);
				2'b01:   fill_q <= fill_q - FILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign stat.fill = fill_q;
	assign stat.full = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign stat.head = mem_q[head_q];

	// The fill count never passes the depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("queue fill above depth");

	// A pop needs a packet, either waiting or arriving now.
	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> (fill_q != '0) || ctrl.push)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

/* rtl/tbs_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket shaper core
// Handles one event per cycle while ev_valid is high: bucket update, queue admission and release.
// ----------------------------------------------------------------------------
module tbs_core
	import tbs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ev_valid,
	input  wire func_t            ev_func,
	input  wire logic [TOK_W-1:0] ev_need,
	input  wire logic [TOK_W-1:0] bucket_depth,
	output result_t               res
);

	logic [TOK_W-1:0]  level_q;
	logic [NUM_W-1:0]  arrival_q;
	logic [CNT_W-1:0]  pkt_drop_q;
	logic [CNT_W-1:0]  tok_drop_q;

	q_ctrl_t           qc;
	q_stat_t           qs;

	logic              is_pkt;
	logic [NUM_W-1:0]  pnum;
	logic              too_big;
	logic              push;
	logic              tok_drop;
	logic [TOK_W-1:0]  level_post;
	entry_t            head;
	logic              head_avail;
	logic              rel;
	logic [TOK_W-1:0]  level_new;
	logic [FILL_W-1:0] fill_new;
	logic              pkt_dropped;
	status_t           status;

	tbs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (qc),
		.stat   (qs)
	);

	// Event decode and the head release check.
	always_comb begin
		is_pkt     = (ev_func == FUNC_PACKET);
		pnum       = arrival_q + NUM_W'(1);
		too_big    = ev_need > bucket_depth;
		push       = is_pkt && !too_big && !qs.full;
		tok_drop   = level_q >= bucket_depth;
		pkt_dropped = is_pkt && !push;

		if (is_pkt) begin
			if (too_big) begin
				status = ST_TOO_BIG;
			end else if (qs.full) begin
				status = ST_Q_FULL;
			end else begin
				status = ST_QUEUED;
			end
		end else begin
			status = tok_drop ? ST_TOK_DROP : ST_TOK_ADD;
		end

		// A tick that is not dropped raises the level before the check.
		if (!is_pkt && !tok_drop) begin
			level_post = level_q + TOK_W'(1);
		end else begin
			level_post = level_q;
		end

		// An empty queue takes the arriving packet as its head at once.
		if (qs.fill == '0) begin
			head.num  = pnum;
			head.need = ev_need;
		end else begin
			head = qs.head;
		end
		head_avail = (qs.fill != '0) || push;
		rel        = head_avail && (head.need <= level_post);
		level_new  = rel ? level_post - head.need : level_post;
		fill_new   = qs.fill + FILL_W'(push) - FILL_W'(rel);

		qc.push     = ev_valid && push;
		qc.pop      = ev_valid && rel;
		qc.wr_entry.num  = pnum;
		qc.wr_entry.need = ev_need;
	end

	// Bucket level, packet numbering and saturating drop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			arrival_q  <= '0;
			pkt_drop_q <= '0;
			tok_drop_q <= '0;
		end else if (ev_valid) begin
			level_q <= level_new;
			if (is_pkt) begin
				arrival_q <= pnum;
			end
			if (pkt_dropped && (pkt_drop_q != '1)) begin
				pkt_drop_q <= pkt_drop_q + CNT_W'(1);
			end
			if (!is_pkt && tok_drop && (tok_drop_q != '1)) begin
				tok_drop_q <= tok_drop_q + CNT_W'(1);
			end
		end
	end

	// Result word as seen after this event.
	always_comb begin
		res.status     = status;
		res.pnum       = is_pkt ? pnum : '0;
		res.released   = rel;
		res.rel_num    = rel ? head.num : '0;
		res.rel_tokens = rel ? head.need : '0;
		res.level      = level_new;
		res.qcount     = QCNT_W'(fill_new);
		res.pkt_drop   = (pkt_dropped && (pkt_drop_q != '1)) ? pkt_drop_q + CNT_W'(1)
			: pkt_drop_q;
		res.tok_drop   = (!is_pkt && tok_drop && (tok_drop_q != '1))
			? tok_drop_q + CNT_W'(1) : tok_drop_q;
	end

	// A released packet never takes more tokens than the bucket holds.
	a_release_covered: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && rel) |-> (head.need <= level_post))
		else $error("release without enough tokens");

	// Every arrival advances the packet number by one.
	a_number_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && is_pkt) |=> (arrival_q == $past(arrival_q) + NUM_W'(1)))
		else $error("packet number did not advance");

endmodule
`default_nettype wire

/* rtl/token_bucket_shaper.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket shaper
// Top level: stream ports, register port, input and result registers.
// ----------------------------------------------------------------------------
// The shaper takes one event word per clock while downstream keeps up, a packet
// arrival or a token tick, and returns exactly one status word for it. A word
// passes from the input register through the core into the result register,
// from which it is offered downstream; the throughput is one word per cycle
// while m_tready is high, set by the update loop of the bucket level and the
// queue pointers. A finished word waits in the result register while the next
// event is taken. The bucket depth register lies at byte address 0 and should
// only be written while no words are in flight. No clearing pass follows reset.
module token_bucket_shaper
	import tbs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	// Event stream.
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // [15:0] tokens_needed
	input  wire logic                   s_tuser,  // [0] func

	// Status stream.
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [15:0] packet_number, [16] released, [32:17] released_number,
	// [48:33] released_tokens, [64:49] bucket_level, [69:65] queue_count,
	// [85:70] packets_dropped, [101:86] tokens_dropped, rest zero
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic [STATUS_W-1:0]         m_tuser,  // [2:0] status

	// Register port.
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]           prdata,
	output logic                        pready
);

	logic [TOK_W-1:0] depth_q;
	logic             cfg_we;

	logic             valid_s1;
	func_t            func_s1;
	logic [TOK_W-1:0] need_s1;
	logic             advance;

	result_t          res;
	logic             valid_s2;
	result_t          res_s2;

	// Register port: always ready, one register.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (cfg_we && (paddr[ADDR_W-1:2] == REG_BUCKET_DEPTH)) begin
			depth_q <= pwdata[TOK_W-1:0];
		end
	end

	always_comb begin
		if (psel && (paddr[ADDR_W-1:2] == REG_BUCKET_DEPTH)) begin
			prdata = DATA_W'(depth_q);
		end else begin
			prdata = '0;
		end
	end

	// The word in the input register moves on when the result register frees.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= func_t'(s_tuser);
			need_s1 <= s_tdata[TOK_W-1:0];
		end
	end

	tbs_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid     (advance),
		.ev_func      (func_s1),
		.ev_need      (need_s1),
		.bucket_depth (depth_q),
		.res          (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.status;
	assign m_tdata  = OUT_TDATA_W'({res_s2.tok_drop, res_s2.pkt_drop, res_s2.qcount,
		res_s2.level, res_s2.rel_tokens, res_s2.rel_num, res_s2.released, res_s2.pnum});

	// A word leaving the input register is shown on the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result word lost after advance");

endmodule
`default_nettype wire
